// ----- hdl/running_median_filter_1d_unit_macros.svh -----
// Assertion macros shared by the running median filter RTL.
`ifndef RUNNING_MEDIAN_FILTER_1D_UNIT_MACROS_SVH
`define RUNNING_MEDIAN_FILTER_1D_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define RMF_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define RMF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/rmf_pkg.sv -----
// Shared types and constants of the running median filter.
package rmf_pkg;

  localparam int unsigned KW             = 4;
  localparam int unsigned DW             = 32;
  localparam int unsigned MAX_KERNEL_DEF = 15;
  localparam int unsigned SAMPLE_BITS    = 32;
  localparam int unsigned EXT_BITS       = (SAMPLE_BITS > 32) ? 32 :
                                           ((SAMPLE_BITS < 8) ? 8 : SAMPLE_BITS);
  localparam int unsigned QUEUE_DEPTH    = 2;
  localparam int unsigned CFG_IW         = 4;

  localparam logic [CFG_IW-1:0] CFG_KERNEL = 4'd0;
  localparam logic [CFG_IW-1:0] CFG_KIND   = 4'd1;

  localparam logic [KW-1:0] KERNEL_RESET = 4'd3;
  localparam logic [KW-1:0] KERNEL_MIN   = 4'd2;

  typedef enum logic [1:0] {
    KIND_U8     = 2'd0,
    KIND_S16    = 2'd1,
    KIND_WIDE_A = 2'd2,
    KIND_WIDE_B = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_KERNEL = 2'd1,
    ST_SHORT  = 2'd2
  } status_e;

  // Effective kernel length and its half
  typedef struct packed {
    logic [KW-1:0] k;
    logic [KW-1:0] half;
  } kcfg_t;

  // Classified request handed from front to back
  typedef struct packed {
    logic signed [DW-1:0] sample;
    logic                 shift;
    logic                 compute;
    logic [KW-1:0]        cnt;
    logic                 err;
    status_e              code;
    logic                 last;
  } cmd_t;

endpackage

// ----- hdl/rmf_front.sv -----
// Front end: configuration registers, sample extension and request classification.
module rmf_front #(
  parameter int unsigned MAX_KERNEL = rmf_pkg::MAX_KERNEL_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [rmf_pkg::CFG_IW-1:0]       cfg_index_i,
  input  logic [rmf_pkg::DW-1:0]           cfg_data_i,
  input  logic                             push_i,
  input  logic                             full_i,
  input  logic signed [rmf_pkg::DW-1:0]    sample_i,
  input  logic                             row_end_i,
  output rmf_pkg::cmd_t                    cmd_o,
  output logic                             cmd_we_o,
  output rmf_pkg::kcfg_t                   kcfg_o
);

  localparam int unsigned KW       = rmf_pkg::KW;
  localparam int unsigned MAXK_ODD = (MAX_KERNEL % 2 == 0) ? MAX_KERNEL - 1 : MAX_KERNEL;
  localparam int unsigned KMAX_REG = (1 << KW) - 1;
  localparam int unsigned K_CAP    = (MAXK_ODD > KMAX_REG) ? KMAX_REG : MAXK_ODD;
  localparam int unsigned SH       = rmf_pkg::DW - rmf_pkg::EXT_BITS;

  logic [KW-1:0]          kernel_q;
  rmf_pkg::kind_e         kind_q;
  logic [KW-1:0]          fill_q, fill_d, fill_inc;
  logic [KW-1:0]          k_odd, k, half;
  logic                   kernel_err;
  logic                   cfg_we, cfg_hit, accept;
  logic signed [rmf_pkg::DW-1:0] ext;
  rmf_pkg::cmd_t          cmd;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i;
  assign cfg_hit     = cfg_we && ((cfg_index_i == rmf_pkg::CFG_KERNEL) ||
                                  (cfg_index_i == rmf_pkg::CFG_KIND));
  assign accept      = push_i && !full_i;

  // Hold configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kernel_q <= rmf_pkg::KERNEL_RESET;
      kind_q   <= rmf_pkg::KIND_U8;
    end else if (cfg_we) begin
      if (cfg_index_i == rmf_pkg::CFG_KERNEL) begin
        kernel_q <= cfg_data_i[KW-1:0];
      end else if (cfg_index_i == rmf_pkg::CFG_KIND) begin
        kind_q <= rmf_pkg::kind_e'(cfg_data_i[1:0]);
      end
    end
  end

  // Raise even kernels by one, cap at the largest odd length that fits the window
  always_comb begin
    k_odd = kernel_q | KW'(1);
    if (32'(k_odd) > K_CAP) begin
      k = KW'(K_CAP);
    end else begin
      k = k_odd;
    end
    half = k >> 1;
  end

  assign kernel_err  = kernel_q < rmf_pkg::KERNEL_MIN;
  assign kcfg_o.k    = k;
  assign kcfg_o.half = half;

  // Extend the sample per kind
  always_comb begin
    unique case (kind_q)
      rmf_pkg::KIND_U8:  ext = {{(rmf_pkg::DW-8){1'b0}}, sample_i[7:0]};
      rmf_pkg::KIND_S16: ext = {{(rmf_pkg::DW-16){sample_i[15]}}, sample_i[15:0]};
      default:           ext = $signed(sample_i << SH) >>> SH;
    endcase
  end

  // Classify the request: kernel error, shift, compute, result count, row end handling
  always_comb begin
    fill_inc    = (fill_q < k) ? fill_q + KW'(1) : fill_q;
    cmd         = '0;
    cmd.sample  = ext;
    cmd.code    = rmf_pkg::ST_OK;
    fill_d      = fill_q;
    if (kernel_err) begin
      cmd.err  = row_end_i;
      cmd.code = rmf_pkg::ST_KERNEL;
      fill_d   = '0;
    end else begin
      cmd.shift = 1'b1;
      fill_d    = fill_inc;
      if (fill_q < k) begin
        if (fill_inc == k) begin
          cmd.compute = 1'b1;
          cmd.cnt     = half + KW'(1);
        end
      end else begin
        cmd.compute = 1'b1;
        cmd.cnt     = KW'(1);
      end
      if (row_end_i) begin
        fill_d = '0;
        if (fill_inc < k) begin
          cmd.err  = 1'b1;
          cmd.code = rmf_pkg::ST_SHORT;
        end else begin
          cmd.cnt  = cmd.cnt + half;
          cmd.last = 1'b1;
        end
      end
    end
  end

  // Track samples held in the current row; a kernel or kind write restarts it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else if (cfg_hit) begin
      fill_q <= '0;
    end else if (accept) begin
      fill_q <= fill_d;
    end
  end

  assign cmd_o    = cmd;
  assign cmd_we_o = accept;

endmodule

// ----- hdl/rmf_fifo.sv -----
// Small register queue that decouples the front end from the back end.
`include "running_median_filter_1d_unit_macros.svh"

module rmf_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = rmf_pkg::QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             rd_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wptr_q, rptr_q;
  logic [CW-1:0]    cnt_q;

  assign full_o  = cnt_q == CW'(DEPTH);
  assign empty_o = cnt_q == '0;
  assign rdata_o = mem_q[rptr_q];

  // Store the incoming request
  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (wr_i) begin
        wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + PW'(1);
      end
      if (rd_i) begin
        rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + PW'(1);
      end
      if (wr_i && !rd_i) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (rd_i && !wr_i) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

  `RMF_ASSERT_IMPL(a_no_overflow, wr_i, !full_o, "queue written while full")
  `RMF_ASSERT_IMPL(a_no_underflow, rd_i, !empty_o, "queue read while empty")

endmodule

// ----- hdl/rmf_back.sv -----
// Back end: sample window, rank search for the median, and result register.
`include "running_median_filter_1d_unit_macros.svh"

module rmf_back #(
  parameter int unsigned MAX_KERNEL = rmf_pkg::MAX_KERNEL_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  rmf_pkg::kcfg_t                kcfg_i,
  input  logic                          q_empty_i,
  input  rmf_pkg::cmd_t                 q_data_i,
  output logic                          q_rd_o,
  input  logic                          pop_i,
  output logic                          empty_o,
  output logic signed [rmf_pkg::DW-1:0] median_o,
  output logic                          last_o,
  output logic [1:0]                    status_o
);

  localparam int unsigned KW   = rmf_pkg::KW;
  localparam int unsigned KREG = (1 << KW) - 1;
  localparam int unsigned WIN  = (MAX_KERNEL < KREG) ? MAX_KERNEL : KREG;
  localparam int unsigned IW   = $clog2(WIN);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SEARCH = 4'b0010,
    S_EMIT   = 4'b0100,
    S_ERR    = 4'b1000
  } bstate_e;

  bstate_e                       state_q, state_d;
  logic signed [rmf_pkg::DW-1:0] win_q [WIN];
  logic [KW-1:0]                 cand_q, cand_d, cnt_q, cnt_d, rank;
  logic                          last_q, last_d;
  rmf_pkg::status_e              code_q, code_d;
  logic signed [rmf_pkg::DW-1:0] med_q, med_d, cand_val;
  logic [WIN-1:0]                hit;
  logic                          found, win_shift, slot_free, out_we;
  logic                          out_valid_q;
  logic signed [rmf_pkg::DW-1:0] out_med_q, out_med_d;
  logic                          out_last_q, out_last_d;
  rmf_pkg::status_e              out_status_q, out_status_d;

  // Shift the new sample into the window
  always_ff @(posedge clk_i) begin
    if (win_shift) begin
      win_q[0] <= q_data_i.sample;
      for (int i = 1; i < WIN; i++) begin
        win_q[i] <= win_q[i-1];
      end
    end
  end

  // Stable rank of the candidate: smaller entries plus equal entries ahead of it
  always_comb begin
    cand_val = win_q[cand_q[IW-1:0]];
    for (int j = 0; j < WIN; j++) begin
      hit[j] = (KW'(j) < kcfg_i.k) &&
               ((win_q[j] < cand_val) || ((win_q[j] == cand_val) && (KW'(j) < cand_q)));
    end
    rank  = KW'($countones(hit));
    found = rank == kcfg_i.half;
  end

  assign slot_free = !out_valid_q || pop_i;

  // Sequence one request: search, then emit its results, or emit its error result
  always_comb begin
    state_d      = state_q;
    cand_d       = cand_q;
    cnt_d        = cnt_q;
    last_d       = last_q;
    code_d       = code_q;
    med_d        = med_q;
    q_rd_o       = 1'b0;
    win_shift    = 1'b0;
    out_we       = 1'b0;
    out_med_d    = med_q;
    out_last_d   = 1'b0;
    out_status_d = rmf_pkg::ST_OK;
    unique case (state_q)
      S_IDLE: begin
        if (!q_empty_i) begin
          q_rd_o    = 1'b1;
          win_shift = q_data_i.shift;
          cnt_d     = q_data_i.cnt;
          last_d    = q_data_i.last;
          code_d    = q_data_i.code;
          cand_d    = '0;
          if (q_data_i.compute) begin
            state_d = S_SEARCH;
          end else if (q_data_i.err) begin
            state_d = S_ERR;
          end
        end
      end
      S_SEARCH: begin
        if (found) begin
          med_d   = cand_val;
          state_d = S_EMIT;
        end else begin
          cand_d = cand_q + KW'(1);
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          out_we     = 1'b1;
          out_last_d = last_q && (cnt_q == KW'(1));
          cnt_d      = cnt_q - KW'(1);
          if (cnt_q == KW'(1)) begin
            state_d = S_IDLE;
          end
        end
      end
      S_ERR: begin
        if (slot_free) begin
          out_we       = 1'b1;
          out_med_d    = '0;
          out_last_d   = 1'b1;
          out_status_d = code_q;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Hold sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cand_q  <= '0;
      cnt_q   <= '0;
      last_q  <= 1'b0;
      code_q  <= rmf_pkg::ST_OK;
    end else begin
      state_q <= state_d;
      cand_q  <= cand_d;
      cnt_q   <= cnt_d;
      last_q  <= last_d;
      code_q  <= code_d;
    end
  end

  always_ff @(posedge clk_i) begin
    med_q <= med_d;
  end

  // Result register: load when free, drop on pop
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_we) begin
      out_valid_q <= 1'b1;
    end else if (pop_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_we) begin
      out_med_q    <= out_med_d;
      out_last_q   <= out_last_d;
      out_status_q <= out_status_d;
    end
  end

  assign empty_o  = !out_valid_q;
  assign median_o = out_med_q;
  assign last_o   = out_last_q;
  assign status_o = out_status_q;

  `RMF_ASSERT_IMPL(a_search_range, state_q == S_SEARCH, cand_q < kcfg_i.k, "rank search overran kernel")
  `RMF_ASSERT_IMPL(a_emit_count, state_q == S_EMIT, cnt_q != '0, "emit with no results left")
  `RMF_ASSERT_NEXT(a_compute_search, q_rd_o && q_data_i.compute, state_q == S_SEARCH, "compute request skipped search")

endmodule

// ----- hdl/running_median_filter_1d_unit.sv -----
// Running median filter over a row of samples: front end, request queue, back end.
//
// Usage: write kernel_size (index 0) and sample_kind (index 1) on the cfg channel
// while the block is idle; a write to either restarts the row. Push one sample per
// request with row_end marking the row's last sample; pop results while empty is low.
// Each result carries the median, a last flag on the row's final result and a status.
// Flow: the queue registers an accepted request, the back end takes it from the queue
// while idle, the rank search then tests one candidate per cycle until it finds the
// median, and each result enters the result register when it is free; further results
// follow one per cycle while the receiver pops each one.
// The back end takes no new request until it has emitted every result of the last one,
// as it has a single rank-search unit; the two-entry queue lets the front end keep
// taking samples during that time until it fills.
// Reset clears the configuration to kernel 3 and 8-bit unsigned, empties the queue
// and result register and starts a new row; there is no clearing pass.
// When the receiver stalls, the result register holds its value, the back end waits,
// the queue fills and full rises.
module running_median_filter_1d_unit #(
  parameter int unsigned MAX_KERNEL = rmf_pkg::MAX_KERNEL_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [rmf_pkg::CFG_IW-1:0]    cfg_index_i,
  input  logic [rmf_pkg::DW-1:0]        cfg_data_i,
  input  logic                          push,
  output logic                          full,
  input  logic signed [rmf_pkg::DW-1:0] sample_i,
  input  logic                          row_end_i,
  input  logic                          pop,
  output logic                          empty,
  output logic signed [rmf_pkg::DW-1:0] median_o,
  output logic                          last_o,
  output logic [1:0]                    status_o
);

  localparam int unsigned CMD_W = $bits(rmf_pkg::cmd_t);

  rmf_pkg::cmd_t  cmd_in, cmd_out;
  rmf_pkg::kcfg_t kcfg;
  logic           cmd_we, q_full, q_empty, q_rd;

  assign full = q_full;

  rmf_front #(
    .MAX_KERNEL(MAX_KERNEL)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .push_i     (push),
    .full_i     (q_full),
    .sample_i   (sample_i),
    .row_end_i  (row_end_i),
    .cmd_o      (cmd_in),
    .cmd_we_o   (cmd_we),
    .kcfg_o     (kcfg)
  );

  rmf_fifo #(
    .WIDTH(CMD_W),
    .DEPTH(rmf_pkg::QUEUE_DEPTH)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (cmd_we),
    .wdata_i(cmd_in),
    .full_o (q_full),
    .rd_i   (q_rd),
    .rdata_o(cmd_out),
    .empty_o(q_empty)
  );

  rmf_back #(
    .MAX_KERNEL(MAX_KERNEL)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .kcfg_i   (kcfg),
    .q_empty_i(q_empty),
    .q_data_i (cmd_out),
    .q_rd_o   (q_rd),
    .pop_i    (pop),
    .empty_o  (empty),
    .median_o (median_o),
    .last_o   (last_o),
    .status_o (status_o)
  );

endmodule
